// ===== hdl/s2c_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s2c_pkg: shared constants and types
// Widths, register indexes and clamping helpers for the strided filter.
// ----------------------------------------------------------------------------
package s2c_pkg;
  localparam int MaxImageRows = 64;
  localparam int MaxImageCols = 64;
  localparam int MaxKernelDim = 8;
  localparam int SampleWidth  = 16;
  localparam int FracBits     = 14;
  localparam int MaxStep      = 8;
  localparam int OutWidth     = 24;

  localparam int RowW   = $clog2(MaxImageRows);
  localparam int ColW   = $clog2(MaxImageCols);
  localparam int KW     = $clog2(MaxKernelDim);
  localparam int CoefN  = MaxKernelDim * MaxKernelDim;
  localparam int CoefAw = $clog2(CoefN);
  localparam int PixN   = MaxKernelDim * MaxImageCols;
  localparam int PixAw  = $clog2(PixN);
  localparam int ProdW  = 2 * SampleWidth;
  localparam int AccW   = ProdW + $clog2(CoefN) + 1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_ROWS = 3'd0,
    REG_IMAGE_COLS = 3'd1,
    REG_KERNEL_ROWS = 3'd2,
    REG_KERNEL_COLS = 3'd3,
    REG_VSTEP = 3'd4,
    REG_HSTEP = 3'd5,
    REG_FLIP = 3'd6
  } reg_idx_e;

  // Clamp a register value to 1..hi; result holds up to hi.
  function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] hi);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/strided_2d_convolution.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strided_2d_convolution: valid-window strided 2D filter
// Loads a kernel, stores recent image rows and walks each window with one MAC.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake        Payload
// in       input      valid / stall    is_coefficient, sample
// out      output     valid / stall    filtered_value, frame_done
// cfg      input      valid / ready    index, data
// A coefficient or a sample that completes no window leaves the block in ST_IDLE.
// A completing sample passes through ST_RUN, which issues one registered RAM read
// per kernel entry and feeds the MAC, then ST_DRAIN, which empties the product and
// accumulate registers, and then ST_OUT, which loads the output register.
// The output register loads only once the previous result has left, so output
// stalls hold the block in ST_OUT. The input also stalls while a configuration
// write is offered, and configuration is taken only between windows.
// Reset is asynchronous and active low; both stores are left unset.
module strided_2d_convolution (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        is_coefficient_i,
  input  wire logic signed [15:0] sample_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [23:0] filtered_value_o,
  output logic             frame_done_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [s2c_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [s2c_pkg::CfgDataW-1:0] cfg_data_i
);
  import s2c_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [6:0] rows_q, cols_q;
  logic [3:0] kr_q, kc_q, vs_q, hs_q;
  logic       flip_q;
  logic [CoefAw-1:0] cidx_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [2:0] rph_q, cph_q;
  logic [KW-1:0] k_q, l_q;
  logic [RowW-1:0] top_q;
  logic [ColW-1:0] left_q;
  logic last_q;
  logic [1:0] pipe_q;
  logic out_valid_q, frame_done_q;
  logic signed [23:0] res_q;

  logic [6:0] rows, cols;
  logic [3:0] kr, kc, vs, hs;
  assign rows = clamp7(rows_q, 7'(MaxImageRows));
  assign cols = clamp7(cols_q, 7'(MaxImageCols));
  assign kr = 4'(clamp7({3'b0, kr_q}, 7'(MaxKernelDim)));
  assign kc = 4'(clamp7({3'b0, kc_q}, 7'(MaxKernelDim)));
  assign vs = 4'(clamp7({3'b0, vs_q}, 7'(MaxStep)));
  assign hs = 4'(clamp7({3'b0, hs_q}, 7'(MaxStep)));

  logic accept, cfg_we, is_coef;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign in_stall_o = (state_q != ST_IDLE) || cfg_valid_i;
  assign accept = in_valid_i && !in_stall_o;
  assign is_coef = is_coefficient_i;

  // Window test. The stride phases of the current row and column are counted
  // as the position advances, so no division is needed.
  logic [6:0] rp1, cp1;
  logic [6:0] tr, tc;
  logic hit;
  assign rp1 = 7'(row_q) + 7'd1;
  assign cp1 = 7'(col_q) + 7'd1;
  assign tr = rp1 - 7'(kr);
  assign tc = cp1 - 7'(kc);
  assign hit = (rp1 >= 7'(kr)) && (cp1 >= 7'(kc)) && (rph_q == 3'd0) && (cph_q == 3'd0);

  // Store addressing.
  logic [CoefAw-1:0] craddr;
  logic [PixAw-1:0]  praddr, pwaddr;
  logic [KW-1:0] ck, cl;
  logic [RowW-1:0] prow;
  logic signed [15:0] coef_rd, pix_rd;
  assign ck = flip_q ? KW'(kr - 4'd1 - 4'(k_q)) : k_q;
  assign cl = flip_q ? KW'(kc - 4'd1 - 4'(l_q)) : l_q;
  assign craddr = CoefAw'(7'(ck) * 7'(kc) + 7'(cl));
  assign prow = top_q + RowW'(k_q);
  assign praddr = {prow[KW-1:0], ColW'(left_q + ColW'(l_q))};
  assign pwaddr = {row_q[KW-1:0], col_q};

  s2c_ram #(.Width(SampleWidth), .Depth(CoefN)) u_coef (
    .clk_i, .we_i(accept && is_coef), .waddr_i(cidx_q), .wdata_i(sample_i),
    .raddr_i(craddr), .rdata_o(coef_rd)
  );
  s2c_ram #(.Width(SampleWidth), .Depth(PixN)) u_rows (
    .clk_i, .we_i(accept && !is_coef), .waddr_i(pwaddr), .wdata_i(sample_i),
    .raddr_i(praddr), .rdata_o(pix_rd)
  );

  logic signed [23:0] mac_res;
  logic step_last;
  assign step_last = (4'(k_q) == kr - 4'd1) && (4'(l_q) == kc - 4'd1);
  s2c_mac u_mac (
    .clk_i, .rst_ni, .clear_i(accept), .mul_en_i(pipe_q[0]), .acc_en_i(pipe_q[1]),
    .coef_i(coef_rd), .pix_i(pix_rd), .result_o(mac_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && !is_coef && hit) state_d = ST_RUN;
      ST_RUN:   if (step_last) state_d = ST_DRAIN;
      ST_DRAIN: if (pipe_q == 2'b10) state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rows_q <= 7'd64; cols_q <= 7'd64; kr_q <= 4'd3; kc_q <= 4'd3;
      vs_q <= 4'd1; hs_q <= 4'd1; flip_q <= 1'b0;
      cidx_q <= '0; row_q <= '0; col_q <= '0;
      rph_q <= '0; cph_q <= '0;
      k_q <= '0; l_q <= '0; pipe_q <= '0;
      top_q <= '0; left_q <= '0; last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pipe_q <= {pipe_q[0], state_q == ST_RUN};
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      if (state_q == ST_RUN) begin
        if (4'(l_q) == kc - 4'd1) begin
          l_q <= '0; k_q <= k_q + 1'b1;
        end else l_q <= l_q + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index_i)
          REG_IMAGE_ROWS:  rows_q <= cfg_data_i;
          REG_IMAGE_COLS:  cols_q <= cfg_data_i;
          REG_KERNEL_ROWS: kr_q <= cfg_data_i[3:0];
          REG_KERNEL_COLS: kc_q <= cfg_data_i[3:0];
          REG_VSTEP:       vs_q <= cfg_data_i[3:0];
          REG_HSTEP:       hs_q <= cfg_data_i[3:0];
          REG_FLIP:        flip_q <= cfg_data_i[0];
          default: ;
        endcase
        if (cfg_index_i <= REG_FLIP) begin
          cidx_q <= '0; row_q <= '0; col_q <= '0;
          rph_q <= '0; cph_q <= '0;
        end
      end else if (accept) begin
        if (is_coef) begin
          if (7'(cidx_q) + 7'd1 >= 7'(kr) * 7'(kc)) cidx_q <= '0;
          else cidx_q <= cidx_q + 1'b1;
        end else begin
          k_q <= '0; l_q <= '0;
          top_q <= RowW'(tr); left_q <= ColW'(tc);
          // A window is the last one when no further stride fits in either axis.
          last_q <= (rp1 + 7'(vs) > rows) && (cp1 + 7'(hs) > cols);
          if (cp1 >= cols) begin
            col_q <= '0;
            cph_q <= '0;
            if (rp1 >= rows) begin
              row_q <= '0;
              rph_q <= '0;
            end else begin
              row_q <= RowW'(rp1);
              if (rp1 >= 7'(kr)) rph_q <= (4'(rph_q) == vs - 4'd1) ? '0 : rph_q + 1'b1;
              else rph_q <= '0;
            end
          end else begin
            col_q <= ColW'(cp1);
            if (cp1 >= 7'(kc)) cph_q <= (4'(cph_q) == hs - 4'd1) ? '0 : cph_q + 1'b1;
            else cph_q <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      res_q <= mac_res; frame_done_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_value_o = res_q;
  assign frame_done_o = frame_done_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> in_stall_o) else $error("input taken mid-window");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(filtered_value_o)) else $error("result moved");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
endmodule
`default_nettype wire

// ===== hdl/s2c_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s2c_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module s2c_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/s2c_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s2c_mac: shared multiply-accumulate unit
// Registered product, then accumulate; output shifted, floored and saturated.
// ----------------------------------------------------------------------------
module s2c_mac (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 clear_i,
  input  wire logic                                 mul_en_i,
  input  wire logic                                 acc_en_i,
  input  wire logic signed [s2c_pkg::SampleWidth-1:0] coef_i,
  input  wire logic signed [s2c_pkg::SampleWidth-1:0] pix_i,
  output logic signed [s2c_pkg::OutWidth-1:0]       result_o
);
  import s2c_pkg::*;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
    end else if (acc_en_i) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en_i) prod_q <= coef_i * pix_i;
  end

  // Arithmetic shift floors toward minus infinity.
  assign shifted = acc_q >>> FracBits;
  always_comb begin
    if (shifted > AccW'(signed'({1'b0, {(OutWidth-1){1'b1}}})))
      result_o = {1'b0, {(OutWidth-1){1'b1}}};
    else if (shifted < -AccW'(signed'({1'b0, 1'b1, {(OutWidth-1){1'b0}}})))
      result_o = {1'b1, {(OutWidth-1){1'b0}}};
    else
      result_o = shifted[OutWidth-1:0];
  end
endmodule
`default_nettype wire

// ===== dv/strided_2d_convolution_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_2d_convolution_checker: result predictor and scoreboard
// Watches the configuration, input and output channels of the filter, keeps
// its own copy of the registers, kernel and row buffer, predicts each window
// sum and compares every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module strided_2d_convolution_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         is_coefficient_i,
  input  logic signed [15:0]           sample_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [23:0]           filtered_value_i,
  input  logic                         frame_done_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [s2c_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [s2c_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           mismatches_o,
  output int                           pending_o
);
  import s2c_pkg::*;

  typedef struct packed {
    logic signed [23:0] value;
    logic               done;
  } window_result_t;

  window_result_t window_q[$];
  logic [6:0]     reg_q[7];
  longint         kernel_mem[CoefN];
  longint         line_mem[PixN];
  int             coef_pos;
  int             row_pos;
  int             col_pos;

  assign pending_o = window_q.size();

  function automatic int clamp_reg(input logic [6:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  task automatic report(input string what, input longint exp_v, input longint act_v);
    mismatches_o++;
    if (mismatches_o <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  task automatic predict_sample(input logic coef, input logic signed [15:0] smp);
    int rows, cols, kr, kc, vs, hs, r, c, top, left, ck, cl;
    longint acc, res;
    window_result_t item;
    rows = clamp_reg(reg_q[REG_IMAGE_ROWS], MaxImageRows);
    cols = clamp_reg(reg_q[REG_IMAGE_COLS], MaxImageCols);
    kr   = clamp_reg(reg_q[REG_KERNEL_ROWS], MaxKernelDim);
    kc   = clamp_reg(reg_q[REG_KERNEL_COLS], MaxKernelDim);
    vs   = clamp_reg(reg_q[REG_VSTEP], MaxStep);
    hs   = clamp_reg(reg_q[REG_HSTEP], MaxStep);
    if (coef) begin
      kernel_mem[coef_pos % CoefN] = longint'(smp);
      coef_pos++;
      if (coef_pos >= kr * kc) coef_pos = 0;
      return;
    end
    r = row_pos % rows;
    c = col_pos % cols;
    line_mem[(r % MaxKernelDim) * MaxImageCols + c] = longint'(smp);
    if (r + 1 >= kr && c + 1 >= kc && (r + 1 - kr) % vs == 0 && (c + 1 - kc) % hs == 0) begin
      top  = r + 1 - kr;
      left = c + 1 - kc;
      acc  = 0;
      for (int k = 0; k < kr; k++) begin
        for (int l = 0; l < kc; l++) begin
          ck = reg_q[REG_FLIP][0] ? kr - 1 - k : k;
          cl = reg_q[REG_FLIP][0] ? kc - 1 - l : l;
          acc += kernel_mem[ck * kc + cl] *
                 line_mem[((top + k) % MaxKernelDim) * MaxImageCols + left + l];
        end
      end
      // An arithmetic shift of a signed value rounds towards minus infinity.
      res = acc >>> FracBits;
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
      item.value = res[23:0];
      item.done  = (top == ((rows - kr) / vs) * vs) && (left == ((cols - kc) / hs) * hs);
      window_q.push_back(item);
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t exp_item;
    if (!rst_ni) begin
      reg_q[REG_IMAGE_ROWS]  = 7'd64;
      reg_q[REG_IMAGE_COLS]  = 7'd64;
      reg_q[REG_KERNEL_ROWS] = 7'd3;
      reg_q[REG_KERNEL_COLS] = 7'd3;
      reg_q[REG_VSTEP]       = 7'd1;
      reg_q[REG_HSTEP]       = 7'd1;
      reg_q[REG_FLIP]        = 7'd0;
      coef_pos = 0;
      row_pos  = 0;
      col_pos  = 0;
      mismatches_o = 0;
      window_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= REG_FLIP) begin
        case (cfg_index_i)
          REG_IMAGE_ROWS, REG_IMAGE_COLS: reg_q[cfg_index_i] = cfg_data_i;
          REG_FLIP: reg_q[cfg_index_i] = {6'd0, cfg_data_i[0]};
          default: reg_q[cfg_index_i] = {3'd0, cfg_data_i[3:0]};
        endcase
        coef_pos = 0;
        row_pos  = 0;
        col_pos  = 0;
      end
      if (in_valid_i && !in_stall_i) predict_sample(is_coefficient_i, sample_i);
      if (out_valid_i && !out_stall_i) begin
        if (window_q.size() == 0) begin
          report("unexpected result", 0, filtered_value_i);
        end else begin
          exp_item = window_q.pop_front();
          if (exp_item.value !== filtered_value_i)
            report("filtered_value", exp_item.value, filtered_value_i);
          if (exp_item.done !== frame_done_i)
            report("frame_done", exp_item.done, frame_done_i);
        end
      end
    end
  end
endmodule

// ===== dv/strided_2d_convolution_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_2d_convolution_tb: stimulus and verdict for the strided filter
// Loads kernels and raster frames under many register settings, with random
// gaps on the input side and random back-pressure on the output side.
// ----------------------------------------------------------------------------
module strided_2d_convolution_tb;
  import s2c_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles  = 80;
  localparam int SampleTarget  = 1200;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                is_coef;
  logic signed [15:0]  sample;
  logic                out_valid;
  logic                out_stall;
  logic signed [23:0]  filtered_value;
  logic                frame_done;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  mismatches;
  int                  pending;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  quiet_cycles = 0;
  int                  samples_sent;

  strided_2d_convolution dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .is_coefficient_i(is_coef), .sample_i(sample),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .filtered_value_o(filtered_value), .frame_done_o(frame_done),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  strided_2d_convolution_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .is_coefficient_i(is_coef), .sample_i(sample),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .filtered_value_i(filtered_value), .frame_done_i(frame_done),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int eff_dim(input logic [6:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(input logic coef, input logic signed [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    is_coef  <= coef;
    sample   <= val;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Hold the input off until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic [6:0] rows, input logic [6:0] cols, input logic [6:0] kr,
                       input logic [6:0] kc, input logic [6:0] vs, input logic [6:0] hs,
                       input logic [6:0] flip);
    drain();
    write_reg(REG_IMAGE_ROWS, rows);
    write_reg(REG_IMAGE_COLS, cols);
    write_reg(REG_KERNEL_ROWS, kr);
    write_reg(REG_KERNEL_COLS, kc);
    write_reg(REG_VSTEP, vs);
    write_reg(REG_HSTEP, hs);
    write_reg(REG_FLIP, flip);
  endtask

  initial begin
    logic [6:0] rows, cols, kr, kc, vs, hs;
    int n_rows, n_cols, n_coef, frames;
    bit aborted, parked;
    rst_n = 1'b0;
    in_valid = 1'b0;
    is_coef = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 25;
    recv_stall_pct = 87;
    samples_sent = 0;
    parked = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole kernel store once so that no window reads an unset entry.
    setup(7'd64, 7'd64, 7'd8, 7'd8, 7'd1, 7'd1, 7'd0);
    for (int i = 0; i < CoefN; i++) send(1'b1, pick_value());

    // Directed: extreme values through a 2x2 kernel on a 3x3 image.
    setup(7'd3, 7'd3, 7'd2, 7'd2, 7'd1, 7'd1, 7'd0);
    send(1'b1, 16'sh7fff);
    send(1'b1, 16'sh8000);
    send(1'b1, 16'sh8000);
    send(1'b1, 16'sh7fff);
    for (int i = 0; i < 9; i++) send(1'b0, (i % 2) ? 16'sh8000 : 16'sh7fff);
    // Flipped kernel, then a kernel larger than the image.
    setup(7'd3, 7'd3, 7'd2, 7'd2, 7'd1, 7'd1, 7'd1);
    for (int i = 0; i < 9; i++) send(1'b0, 16'sh7fff - 16'(i));
    setup(7'd2, 7'd2, 7'd3, 7'd3, 7'd1, 7'd1, 7'd1);
    for (int i = 0; i < 4; i++) send(1'b0, 16'sh8000);

    while (samples_sent < SampleTarget) begin
      if (samples_sent < SampleTarget / 3) begin
        send_idle_pct = 25;
        recv_stall_pct = 87;
      end else if (samples_sent < 2 * SampleTarget / 3) begin
        send_idle_pct = 87;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(9))
        0: begin rows = 7'd64; cols = 7'($urandom_range(1, 3)); end
        1: begin rows = 7'($urandom_range(1, 3)); cols = 7'd64; end
        2: begin rows = 7'($urandom_range(0, 1) ? 0 : $urandom_range(100, 127)); cols = 7'd2; end
        default: begin rows = 7'($urandom_range(1, 10)); cols = 7'($urandom_range(1, 10)); end
      endcase
      kr = 7'($urandom_range(9) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 4));
      kc = 7'($urandom_range(9) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 4));
      vs = 7'($urandom_range(4) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 3));
      hs = 7'($urandom_range(4) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 3));
      setup(rows, cols, kr, kc, vs, hs, 7'($urandom));
      n_rows = eff_dim(rows, MaxImageRows);
      n_cols = eff_dim(cols, MaxImageCols);
      n_coef = eff_dim({3'd0, kr[3:0]}, MaxKernelDim) * eff_dim({3'd0, kc[3:0]}, MaxKernelDim);
      for (int i = 0; i < n_coef; i++) send(1'b1, pick_value());
      frames = $urandom_range(1, 2);
      aborted = 0;
      for (int f = 0; f < frames && !aborted; f++) begin
        for (int p = 0; p < n_rows * n_cols && samples_sent < SampleTarget; p++) begin
          if ($urandom_range(99) < 3) send(1'b1, pick_value());
          if ($urandom_range(199) == 0) begin
            aborted = 1;
            break;
          end
          // Once, stop mid-frame until all results are out; an unused index
          // must not disturb the frame position.
          if (!parked && samples_sent > SampleTarget / 2 && p == (n_rows * n_cols) / 2) begin
            parked = 1;
            drain();
            write_reg(RegUnused, 7'($urandom));
          end
          send(1'b0, pick_value());
        end
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/s2c_pkg.sv
hdl/s2c_ram.sv
hdl/s2c_mac.sv
hdl/strided_2d_convolution.sv
dv/strided_2d_convolution_checker.sv
dv/strided_2d_convolution_tb.sv
